// ===== sv/lscs_pkg.sv =====
`default_nettype none

package lscs_pkg;

  localparam int SAMPLE_W = 8;
  localparam int STEER_W = 3;
  localparam int THR_W = 7;
  localparam int SUM_W = 14;
  localparam int CAL_LEN_DEFAULT = 50;

  typedef enum logic [STEER_W-1:0] {
    STEER_STRAIGHT = 3'd0,
    STEER_LEFT     = 3'd1,
    STEER_RIGHT    = 3'd2,
    STEER_HOLD     = 3'd3,
    STEER_CAL      = 3'd4
  } steer_t;

  // compare results of one side sensor against the middle one
  typedef struct packed {
    logic below;  // side < middle
    logic above;  // side > middle
    logic far;    // side - middle > threshold
    logic near;   // side - middle < threshold
  } lane_flags_t;

endpackage

`default_nettype wire

// ===== sv/lscs_if.sv =====
`default_nettype none

interface lscs_in_if;
  logic                          valid;
  logic                          ready;
  logic [lscs_pkg::SAMPLE_W-1:0] left_sample;
  logic [lscs_pkg::SAMPLE_W-1:0] middle_sample;
  logic [lscs_pkg::SAMPLE_W-1:0] right_sample;

  modport source (
    output valid, left_sample, middle_sample, right_sample,
    input  ready
  );
  modport sink (
    input  valid, left_sample, middle_sample, right_sample,
    output ready
  );
endinterface

interface lscs_out_if;
  logic                         valid;
  logic                         ready;
  logic [lscs_pkg::STEER_W-1:0] steer;
  logic [lscs_pkg::THR_W-1:0]   current_threshold;

  modport source (
    output valid, steer, current_threshold,
    input  ready
  );
  modport sink (
    input  valid, steer, current_threshold,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/lscs_lane.sv =====
`default_nettype none

module lscs_lane (
  input  wire logic [lscs_pkg::SAMPLE_W-1:0] side,
  input  wire logic [lscs_pkg::SAMPLE_W-1:0] middle,
  input  wire logic [lscs_pkg::THR_W-1:0]    thr,
  output lscs_pkg::lane_flags_t              flags
);

  logic signed [lscs_pkg::SAMPLE_W+1:0] diff;
  logic signed [lscs_pkg::SAMPLE_W+1:0] thr_s;

  assign diff  = $signed({2'b00, side}) - $signed({2'b00, middle});
  assign thr_s = $signed({{(lscs_pkg::SAMPLE_W + 2 - lscs_pkg::THR_W){1'b0}}, thr});

  always_comb begin
    flags.below = side < middle;
    flags.above = side > middle;
    flags.far   = diff > thr_s;
    flags.near  = diff < thr_s;
  end

endmodule

`default_nettype wire

// ===== sv/lscs_merge.sv =====
`default_nettype none

module lscs_merge (
  input  wire lscs_pkg::lane_flags_t         left_flags,
  input  wire lscs_pkg::lane_flags_t         right_flags,
  input  wire logic [lscs_pkg::SAMPLE_W-1:0] middle,
  input  wire logic [lscs_pkg::SAMPLE_W-1:0] lowest,
  input  wire logic [lscs_pkg::SAMPLE_W-1:0] highest,
  input  wire logic [lscs_pkg::THR_W-1:0]    thr,
  output lscs_pkg::steer_t                   code
);

  logic signed [lscs_pkg::SAMPLE_W+1:0] mid_over_low;
  logic signed [lscs_pkg::SAMPLE_W+1:0] high_over_mid;
  logic signed [lscs_pkg::SAMPLE_W+1:0] thr_s;
  logic                                 straight;

  assign mid_over_low  = $signed({2'b00, middle}) - $signed({2'b00, lowest});
  assign high_over_mid = $signed({2'b00, highest}) - $signed({2'b00, middle});
  assign thr_s = $signed({{(lscs_pkg::SAMPLE_W + 2 - lscs_pkg::THR_W){1'b0}}, thr});

  // middle clearly darker than both sides and inside the calibrated span
  assign straight = (mid_over_low < thr_s) && (high_over_mid > thr_s) &&
                    left_flags.above && right_flags.above &&
                    left_flags.far && right_flags.far;

  always_comb begin
    priority if (straight) begin
      code = lscs_pkg::STEER_STRAIGHT;
    end else if (left_flags.below || left_flags.near) begin
      code = lscs_pkg::STEER_LEFT;
    end else if (right_flags.below || right_flags.near) begin
      code = lscs_pkg::STEER_RIGHT;
    end else begin
      code = lscs_pkg::STEER_HOLD;
    end
  end

endmodule

`default_nettype wire

// ===== sv/line_sensor_calibrate_and_steer.sv =====
// timing: a result is registered in the cycle after its input transaction, except that the
//   last calibration result waits for the reciprocal divide in ST_MUL and ST_DIV
// throughput: one item per cycle while the result side does not stall; the input is held off
//   after the last calibration item, through ST_MUL and ST_DIV, while the threshold is formed
// reset: synchronous rst clears the handshake and sequencer state, calibration restarts
`default_nettype none

module line_sensor_calibrate_and_steer #(
  parameter int CAL_LEN = lscs_pkg::CAL_LEN_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  lscs_in_if.sink           samples,
  lscs_out_if.source        result
);

  localparam int SW = lscs_pkg::SAMPLE_W;
  localparam int SUM_W = lscs_pkg::SUM_W;
  localparam int THR_W = lscs_pkg::THR_W;
  localparam int CNT_W = $clog2(CAL_LEN + 1);

  // exact floor(x / CAL_LEN) for any SUM_W-bit x: (x * RECIP) >> CAL_SHIFT
  localparam int CAL_SHIFT = SUM_W + $clog2(CAL_LEN);
  localparam int RECIP = ((1 << CAL_SHIFT) + CAL_LEN - 1) / CAL_LEN;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  // calibration sequencer
  typedef enum logic [3:0] {
    ST_CAL = 4'b0001,  // taking calibration items
    ST_MUL = 4'b0010,  // reciprocal products of the sums
    ST_DIV = 4'b0100,  // threshold formed, last calibration result issued
    ST_RUN = 4'b1000   // steering
  } state_t;

  state_t state;

  logic [CNT_W-1:0] cal_seen;
  logic [SW-1:0]    lowest;
  logic [SW-1:0]    highest;
  logic [SUM_W-1:0] sum_lo;
  logic [SUM_W-1:0] sum_hi;
  logic [THR_W-1:0] threshold;
  logic [PROD_W-1:0] prod_lo;
  logic [PROD_W-1:0] prod_hi;

  // output register
  logic                         out_valid;
  logic [lscs_pkg::STEER_W-1:0] out_steer;
  logic [THR_W-1:0]             out_thr;

  logic out_free;
  logic out_load;
  logic in_ready;
  logic in_fire;
  logic cal_first;
  logic cal_last;

  logic [SW-1:0] lm_min;
  logic [SW-1:0] lm_max;
  logic [SW-1:0] item_lo;
  logic [SW-1:0] item_hi;

  logic [SUM_W-1:0] avg_lo;
  logic [SUM_W-1:0] avg_hi;
  logic [SUM_W-1:0] avg_half;
  logic [THR_W-1:0] thr_calc;

  lscs_pkg::lane_flags_t left_flags;
  lscs_pkg::lane_flags_t right_flags;
  lscs_pkg::steer_t      run_code;

  // handshake: the output register frees when its transaction completes
  assign out_free = !out_valid || result.ready;
  assign in_ready = ((state == ST_CAL) || (state == ST_RUN)) && out_free;
  assign in_fire  = samples.valid && in_ready;

  // a new result enters the output register
  assign out_load = (in_fire && (((state == ST_CAL) && !cal_last) || (state == ST_RUN))) ||
                    ((state == ST_DIV) && out_free);

  assign samples.ready            = in_ready;
  assign result.valid             = out_valid;
  assign result.steer             = out_steer;
  assign result.current_threshold = out_thr;

  assign cal_first = (cal_seen == '0);
  assign cal_last  = (cal_seen == CNT_W'(CAL_LEN - 1));

  // per-item minimum and maximum of the three samples
  always_comb begin
    lm_min  = (samples.middle_sample < samples.left_sample) ?
              samples.middle_sample : samples.left_sample;
    lm_max  = (samples.middle_sample > samples.left_sample) ?
              samples.middle_sample : samples.left_sample;
    item_lo = (samples.right_sample < lm_min) ? samples.right_sample : lm_min;
    item_hi = (samples.right_sample > lm_max) ? samples.right_sample : lm_max;
  end

  // threshold from the registered products: shift, subtract, halve, clamp
  always_comb begin
    avg_lo = SUM_W'(prod_lo >> CAL_SHIFT);
    avg_hi = SUM_W'(prod_hi >> CAL_SHIFT);
    avg_half = (avg_hi >= avg_lo) ? ((avg_hi - avg_lo) >> 1) : '0;
    thr_calc = (avg_half[SUM_W-1:THR_W] != '0) ? {THR_W{1'b1}} : avg_half[THR_W-1:0];
  end

  // one lane per side sensor, each compared against the middle one
  lscs_lane u_lane_left (
    .side   (samples.left_sample),
    .middle (samples.middle_sample),
    .thr    (threshold),
    .flags  (left_flags)
  );

  lscs_lane u_lane_right (
    .side   (samples.right_sample),
    .middle (samples.middle_sample),
    .thr    (threshold),
    .flags  (right_flags)
  );

  // merge both lanes with the middle-sensor span check
  lscs_merge u_merge (
    .left_flags  (left_flags),
    .right_flags (right_flags),
    .middle      (samples.middle_sample),
    .lowest      (lowest),
    .highest     (highest),
    .thr         (threshold),
    .code        (run_code)
  );

  // output valid: set by a new result, cleared when its transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CAL;
      cal_seen  <= '0;
      threshold <= '0;
    end else begin
      unique case (state)
        ST_CAL: begin
          if (in_fire) begin
            cal_seen <= cal_seen + CNT_W'(1);
            if (cal_last) begin
              // result waits for the threshold
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (out_free) begin
            threshold <= thr_calc;
            state     <= ST_RUN;
          end
        end
        ST_RUN: begin
          // steering until the next reset
        end
        default: begin
          state <= ST_CAL;
        end
      endcase
    end
  end

  // calibration accumulators; the first item seeds them
  always_ff @(posedge clk) begin
    if ((state == ST_CAL) && in_fire) begin
      if (cal_first) begin
        lowest  <= item_lo;
        highest <= item_hi;
        sum_lo  <= SUM_W'(item_lo);
        sum_hi  <= SUM_W'(item_hi);
      end else begin
        if (item_lo < lowest) begin
          lowest <= item_lo;
        end
        if (item_hi > highest) begin
          highest <= item_hi;
        end
        sum_lo <= sum_lo + SUM_W'(item_lo);
        sum_hi <= sum_hi + SUM_W'(item_hi);
      end
    end
  end

  // reciprocal multiply, one per sum
  always_ff @(posedge clk) begin
    prod_lo <= PROD_W'(sum_lo) * PROD_W'(RECIP_C);
    prod_hi <= PROD_W'(sum_hi) * PROD_W'(RECIP_C);
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((state == ST_CAL) && in_fire) begin
      out_steer <= lscs_pkg::STEER_CAL;
      out_thr   <= '0;
    end else if ((state == ST_DIV) && out_free) begin
      out_steer <= lscs_pkg::STEER_CAL;
      out_thr   <= thr_calc;
    end else if ((state == ST_RUN) && in_fire) begin
      out_steer <= run_code;
      out_thr   <= threshold;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lscs_check.sv =====
`default_nettype none

module lscs_check (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [lscs_pkg::STEER_W-1:0] steer,
  input wire logic [lscs_pkg::THR_W-1:0]   thr
);

  logic [1:0]                   pending;
  logic                         done_seen;
  logic [lscs_pkg::THR_W-1:0]   last_thr;
  logic                         in_fire;
  logic                         out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      done_seen <= 1'b0;
      last_thr  <= '0;
    end else begin
      if (in_fire && !out_fire) begin
        pending <= pending + 2'd1;
      end else if (out_fire && !in_fire) begin
        pending <= pending - 2'd1;
      end
      if (out_fire && (steer != lscs_pkg::STEER_CAL)) begin
        done_seen <= 1'b1;
        last_thr  <= thr;
      end
    end
  end

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(steer) && $stable(thr))
    else $error("result changed while stalled");

  // no result without an accepted item behind it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result without pending item");

  // once steering has begun, calibration never reappears
  a_no_recal: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_seen |-> steer != lscs_pkg::STEER_CAL)
    else $error("calibration code after steering began");

  // the threshold is frozen once steering has begun
  a_thr_frozen: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_seen |-> thr == last_thr)
    else $error("threshold changed after calibration");

endmodule

bind line_sensor_calibrate_and_steer lscs_check u_lscs_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .steer     (result.steer),
  .thr       (result.current_threshold)
);

`default_nettype wire

// ===== test/lscs_checker.sv =====
`default_nettype none

module lscs_checker #(
  parameter int CAL_LEN = lscs_pkg::CAL_LEN_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  lscs_in_if        samples,
  lscs_out_if       result,
  output int        mismatches,
  output int        outstanding,
  output int        checked
);

  localparam int SAMPLE_W = lscs_pkg::SAMPLE_W;
  localparam int SUM_W = lscs_pkg::SUM_W;
  localparam int THR_W = lscs_pkg::THR_W;

  typedef struct packed {
    lscs_pkg::steer_t steer;
    logic [THR_W-1:0] thr;
  } steer_result_t;

  steer_result_t         steer_due[$];

  logic [6:0]            cal_seen;
  logic [SAMPLE_W-1:0]   floor_seen;
  logic [SAMPLE_W-1:0]   peak_seen;
  logic [SUM_W-1:0]      sum_minima;
  logic [SUM_W-1:0]      sum_maxima;
  logic [THR_W-1:0]      thr_now;

  // signed compares of both sides against the middle sensor
  function automatic lscs_pkg::steer_t decide_steer(input int sl, input int sm, input int sr,
                                                    input int t, input int lo, input int hi);
    if ((sm - lo) < t && (hi - sm) > t && sm < sl && sm < sr &&
        (sr - sm) > t && (sl - sm) > t)
      return lscs_pkg::STEER_STRAIGHT;
    if (sl < sm || (sl - sm) < t)
      return lscs_pkg::STEER_LEFT;
    if (sr < sm || (sr - sm) < t)
      return lscs_pkg::STEER_RIGHT;
    return lscs_pkg::STEER_HOLD;
  endfunction

  task automatic flag(input string what, input int want_v, input int got_v);
    mismatches++;
    $display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    steer_result_t       want;
    steer_result_t       got;
    logic [SAMPLE_W-1:0] l, m, r, mn, mx;
    int                  avg_lo, avg_hi, t;
    if (rst) begin
      steer_due.delete();
      cal_seen   = '0;
      floor_seen = '0;
      peak_seen  = '0;
      sum_minima = '0;
      sum_maxima = '0;
      thr_now    = '0;
      mismatches = 0;
      checked    = 0;
    end else begin
      if (samples.valid && samples.ready) begin
        l = samples.left_sample;
        m = samples.middle_sample;
        r = samples.right_sample;
        if (cal_seen < CAL_LEN) begin
          mn = l;
          if (m < mn) mn = m;
          if (r < mn) mn = r;
          mx = l;
          if (m > mx) mx = m;
          if (r > mx) mx = r;
          if (cal_seen == 0) begin
            floor_seen = l;
            peak_seen  = l;
          end
          if (mn < floor_seen) floor_seen = mn;
          if (mx > peak_seen) peak_seen = mx;
          sum_minima = sum_minima + SUM_W'(mn);
          sum_maxima = sum_maxima + SUM_W'(mx);
          cal_seen   = cal_seen + 7'd1;
          want.steer = lscs_pkg::STEER_CAL;
          want.thr   = '0;
          if (cal_seen == CAL_LEN) begin
            avg_lo = int'(sum_minima) / CAL_LEN;
            avg_hi = int'(sum_maxima) / CAL_LEN;
            t = (avg_hi - avg_lo) / 2;
            if (t < 0) t = 0;
            if (t > 127) t = 127;
            thr_now  = t[THR_W-1:0];
            want.thr = thr_now;
          end
        end else begin
          want.steer = decide_steer(int'(l), int'(m), int'(r), int'(thr_now),
                                    int'(floor_seen), int'(peak_seen));
          want.thr   = thr_now;
        end
        steer_due.push_back(want);
      end
      if (result.valid && result.ready) begin
        got.steer = lscs_pkg::steer_t'(result.steer);
        got.thr   = result.current_threshold;
        if (steer_due.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none, actual steer %0d threshold %0d",
                   $time, got.steer, got.thr);
        end else begin
          want = steer_due.pop_front();
          if (got.steer != want.steer)
            flag("steer", int'(want.steer), int'(got.steer));
          if (got.thr != want.thr)
            flag("current_threshold", int'(want.thr), int'(got.thr));
          checked++;
        end
      end
    end
    outstanding = steer_due.size();
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;

  localparam int SAMPLE_W     = lscs_pkg::SAMPLE_W;
  localparam int THR_W        = lscs_pkg::THR_W;
  localparam int CAL_ITEMS    = lscs_pkg::CAL_LEN_DEFAULT;
  localparam int RANDOM_ITEMS = 540;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 8;

  logic clk;
  logic rst;

  lscs_in_if  samples ();
  lscs_out_if result ();

  int mismatches;
  int outstanding;
  int checked;

  // stimulus bookkeeping
  int               cycles = 0;
  int               sent = 0;
  int               results_taken = 0;
  logic [THR_W-1:0] learned_thr = '0;
  int               cal_floor = 255;   // lowest sample over the calibration stream
  int               cal_peak = 0;      // highest sample over the calibration stream
  bit               calm_in = 0;

  line_sensor_calibrate_and_steer #(
    .CAL_LEN(CAL_ITEMS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples),
    .result (result)
  );

  // watches both channels, predicts and compares
  lscs_checker #(
    .CAL_LEN(CAL_ITEMS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .result     (result),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d transactions still expected", cycles,
               outstanding);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [SAMPLE_W-1:0] clip(input int v);
    if (v < 0) return '0;
    if (v > 255) return '1;
    return v[SAMPLE_W-1:0];
  endfunction

  // random jitter around a level, -span..+span
  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // one sample transaction: optional gap with valid low, then hold until accepted
  task automatic send(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] m,
                      input logic [SAMPLE_W-1:0] r);
    int gap;
    // burst stretches with no gaps every now and then
    if (sent % 40 == 0) calm_in = ($urandom_range(0, 3) == 0);
    gap = calm_in ? 0 : int'($urandom_range(0, 4));
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid         <= 1'b1;
    samples.left_sample   <= l;
    samples.middle_sample <= m;
    samples.right_sample  <= r;
    do @(posedge clk); while (!samples.ready);
    // floor and peak matter for shaping the steering stimulus
    if (sent < CAL_ITEMS) begin
      if (int'(l) < cal_floor) cal_floor = int'(l);
      if (int'(m) < cal_floor) cal_floor = int'(m);
      if (int'(r) < cal_floor) cal_floor = int'(r);
      if (int'(l) > cal_peak) cal_peak = int'(l);
      if (int'(m) > cal_peak) cal_peak = int'(m);
      if (int'(r) > cal_peak) cal_peak = int'(r);
    end
    sent++;
  endtask

  // result side: random stalls, with calm stretches, and a tally of taken results
  initial begin
    int stall;
    int n;
    bit calm_out;
    n = 0;
    calm_out = 0;
    result.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (n % 32 == 0) calm_out = ($urandom_range(0, 3) == 0);
      n++;
      stall = calm_out ? 0 : int'($urandom_range(0, 4));
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
      results_taken++;
      learned_thr = result.current_threshold;
    end
  end

  // stimulus and verdict
  initial begin
    int dark, bright, dark_pos, k, j, pick, thr, lo, mi;
    logic [SAMPLE_W-1:0] s [3];

    samples.valid         <= 1'b0;
    samples.left_sample   <= '0;
    samples.middle_sample <= '0;
    samples.right_sample  <= '0;
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // calibration: mostly a dark line under one sensor, bright floor under the others, some random items
    dark   = int'($urandom_range(0, 90));
    bright = int'($urandom_range(140, 255));

    // first item: left sample is the highest, right sample is neither the lowest nor the highest
    send(8'd200, 8'd20, 8'd90);
    for (k = 1; k < CAL_ITEMS; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        send(clip(int'($urandom_range(0, 255))), clip(int'($urandom_range(0, 255))),
             clip(int'($urandom_range(0, 255))));
      end else begin
        dark_pos = int'($urandom_range(0, 2));
        for (j = 0; j < 3; j++)
          s[j] = (j == dark_pos) ? clip(dark + jitter(8)) : clip(bright + jitter(8));
        send(s[0], s[1], s[2]);
      end
    end

    // let the threshold settle before steering starts
    samples.valid <= 1'b0;
    do @(negedge clk); while (results_taken < CAL_ITEMS);
    @(posedge clk);
    thr = int'(learned_thr);
    lo  = cal_floor;

    // directed steering around the learned threshold
    send(clip(lo + thr + 1), clip(lo), clip(lo + thr + 1));      // straight
    send(clip(lo + thr), clip(lo), clip(lo + thr + 1));          // left side right at threshold
    send(clip(lo + 2 * thr), clip(lo + thr), clip(lo + 2 * thr)); // middle at threshold -> hold
    send(clip(lo + thr + 1), clip(lo), clip(lo + thr - 1));      // right side too close
    send(clip(lo + thr - 1), clip(lo), clip(lo + thr + 1));      // left side too close
    send(8'd0, 8'd255, 8'd0);
    send(8'd255, 8'd128, 8'd0);
    send(8'd0, 8'd0, 8'd0);
    send(8'd255, 8'd255, 8'd255);
    send(8'd255, 8'd0, 8'd255);
    send(8'd0, 8'd255, 8'd255);
    send(8'd255, 8'd255, 8'd0);

    // random: half shaped near the straight and hold boundaries, half anything
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      pick = int'($urandom_range(0, 9));
      if (pick < 5) begin
        mi = lo - 1 + int'($urandom_range(0, thr + 2));
        s[0] = clip(mi + thr + jitter(2));
        s[1] = clip(mi);
        s[2] = clip(mi + thr + jitter(2));
        // one side darker than the middle now and then
        if (pick == 0) s[0] = clip(mi - int'($urandom_range(0, 20)));
        if (pick == 1) s[2] = clip(mi - int'($urandom_range(0, 20)));
        send(s[0], s[1], s[2]);
      end else begin
        send(clip(int'($urandom_range(0, 255))), clip(int'($urandom_range(0, 255))),
             clip(int'($urandom_range(0, 255))));
      end
    end

    // drain: wait for every expected result, then let the clock run quietly before the verdict
    samples.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d sample transactions, %0d for calibration; threshold %0d",
             sent, CAL_ITEMS, thr);
    $display("floor %0d peak %0d; compared %0d results, %0d mismatches",
             cal_floor, cal_peak, checked, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
